// ===== hw/rtl/learning_switch_port_security_macros.svh =====
// assertion macros for the learning switch
`ifndef LEARNING_SWITCH_PORT_SECURITY_MACROS_SVH
`define LEARNING_SWITCH_PORT_SECURITY_MACROS_SVH

// same-cycle implication
`define LSPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsps assertion failed");

// next-cycle implication
`define LSPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsps assertion failed");

`endif

// ===== hw/rtl/lsps_pkg.sv =====
`default_nettype none
package lsps_pkg;

    localparam int NUM_PORTS   = 32;
    localparam int FWD_ENTRIES = 1024;
    localparam int FWD_AW      = $clog2(FWD_ENTRIES);
    localparam int FWD_CW      = $clog2(FWD_ENTRIES + 1);
    localparam int SEC_AW      = $clog2(NUM_PORTS);

    localparam logic       KIND_FRAME = 1'b0;
    localparam logic       KIND_WRITE = 1'b1;

    localparam logic [1:0] ACT_DROP       = 2'd0;
    localparam logic [1:0] ACT_REDIRECT   = 2'd1;
    localparam logic [1:0] ACT_CONTROLLER = 2'd2;
    localparam logic [1:0] ACT_WRITTEN    = 2'd3;

    localparam logic [2:0] CAUSE_NONE      = 3'd0;
    localparam logic [2:0] CAUSE_TRUNC     = 3'd1;
    localparam logic [2:0] CAUSE_SRC_MAC   = 3'd2;
    localparam logic [2:0] CAUSE_SRC_IP    = 3'd3;
    localparam logic [2:0] CAUSE_DST_MAC   = 3'd4;
    localparam logic [2:0] CAUSE_SAME_PORT = 3'd5;

    localparam logic [15:0] ETH_HDR_LEN = 16'd14;
    localparam logic [15:0] IP_HDR_END  = 16'd34;
    localparam logic [15:0] ETYPE_IPV4  = 16'h0800;

    typedef struct packed {
        logic        kind;
        logic [4:0]  in_port;
        logic [15:0] captured_len;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [15:0] ethertype;
        logic [31:0] src_ip;
        logic        allow_mac_valid;
        logic [47:0] allow_mac;
        logic        allow_ip_valid;
        logic [31:0] allow_ip;
    } t_in;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] out_port;
        logic [2:0] drop_cause;
    } t_out;

    typedef struct packed {
        logic        mac_valid;
        logic [47:0] mac;
        logic        ip_valid;
        logic [31:0] ip;
    } t_sec;

    typedef struct packed {
        logic              en;
        logic [SEC_AW-1:0] addr;
        t_sec              data;
    } t_sec_wr;

    typedef struct packed {
        logic        fin;
        t_out        res;
        logic [4:0]  port;
        logic [47:0] smac;
        logic [47:0] dmac;
    } t_job;

    typedef struct packed {
        logic [47:0] mac;
        logic [4:0]  port;
    } t_fwd;

    function automatic logic port_ok(input logic [4:0] p);
        return {27'd0, p} < 32'(NUM_PORTS);
    endfunction

    function automatic logic [SEC_AW-1:0] sec_addr(input logic [4:0] p);
        return SEC_AW'(p);
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lsps_sectab.sv =====
`default_nettype none
module lsps_sectab (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire lsps_pkg::t_sec_wr         i_wr,
    input  wire logic                      i_rd_a_en,
    input  wire logic [lsps_pkg::SEC_AW-1:0] i_rd_a_addr,
    output lsps_pkg::t_sec                 o_rd_a,
    input  wire logic                      i_rd_b_en,
    input  wire logic [lsps_pkg::SEC_AW-1:0] i_rd_b_addr,
    output lsps_pkg::t_sec                 o_rd_b
);
    import lsps_pkg::*;

    logic [NUM_PORTS-1:0] r_mac_valid;
    logic [NUM_PORTS-1:0] r_ip_valid;
    logic [47:0]          r_mac_mem [NUM_PORTS];
    logic [31:0]          r_ip_mem  [NUM_PORTS];
    t_sec                 r_rd_a;
    t_sec                 r_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mac_valid <= '0;
            r_ip_valid  <= '0;
        end else if (i_wr.en) begin
            r_mac_valid[i_wr.addr] <= i_wr.data.mac_valid;
            r_ip_valid[i_wr.addr]  <= i_wr.data.ip_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mac_mem[i_wr.addr] <= i_wr.data.mac;
            r_ip_mem[i_wr.addr]  <= i_wr.data.ip;
        end
        if (i_rd_a_en) begin
            r_rd_a <= '{mac_valid: r_mac_valid[i_rd_a_addr], mac: r_mac_mem[i_rd_a_addr],
                        ip_valid: r_ip_valid[i_rd_a_addr], ip: r_ip_mem[i_rd_a_addr]};
        end
        if (i_rd_b_en) begin
            r_rd_b <= '{mac_valid: r_mac_valid[i_rd_b_addr], mac: r_mac_mem[i_rd_b_addr],
                        ip_valid: r_ip_valid[i_rd_b_addr], ip: r_ip_mem[i_rd_b_addr]};
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule
`default_nettype wire

// ===== hw/rtl/lsps_front.sv =====
`default_nettype none
module lsps_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    output logic                             o_full,
    input  wire lsps_pkg::t_in               i_item,
    input  wire logic                        i_drain,
    output logic                             o_rd_en,
    output logic [lsps_pkg::SEC_AW-1:0]      o_rd_addr,
    input  wire lsps_pkg::t_sec              i_rd,
    output lsps_pkg::t_sec_wr                o_wr,
    output logic                             o_q_push,
    input  wire logic                        i_q_full,
    output lsps_pkg::t_job                   o_job
);
    import lsps_pkg::*;

    logic r_vld;
    logic n_vld;
    t_in  r_item;
    logic accept;
    logic go;
    logic ok;

    assign accept    = i_push && !r_vld;
    assign o_full    = r_vld;
    assign o_rd_en   = accept;
    assign o_rd_addr = sec_addr(i_item.in_port);
    assign ok        = port_ok(r_item.in_port);

    always_comb begin
        o_job.fin  = 1'b1;
        o_job.res  = '{action: ACT_DROP, out_port: 5'd0, drop_cause: CAUSE_NONE};
        o_job.port = r_item.in_port;
        o_job.smac = r_item.src_mac;
        o_job.dmac = r_item.dst_mac;
        o_wr.en    = 1'b0;
        o_wr.addr  = sec_addr(r_item.in_port);
        o_wr.data  = '{mac_valid: r_item.allow_mac_valid, mac: r_item.allow_mac,
                       ip_valid: r_item.allow_ip_valid, ip: r_item.allow_ip};
        go         = !i_q_full;
        if (r_item.kind == KIND_WRITE) begin
            // table writes wait until the back end holds nothing in flight
            go               = i_drain && !i_q_full;
            o_job.res.action = ACT_WRITTEN;
            o_wr.en          = r_vld && go && ok;
        end else if (r_item.captured_len < ETH_HDR_LEN) begin
            o_job.res.drop_cause = CAUSE_TRUNC;
        end else if (ok && i_rd.mac_valid && r_item.src_mac != i_rd.mac) begin
            o_job.res.drop_cause = CAUSE_SRC_MAC;
        end else if (r_item.ethertype == ETYPE_IPV4 && ok && i_rd.ip_valid &&
                     r_item.captured_len < IP_HDR_END) begin
            o_job.res.drop_cause = CAUSE_TRUNC;
        end else if (r_item.ethertype == ETYPE_IPV4 && ok && i_rd.ip_valid &&
                     r_item.src_ip != i_rd.ip) begin
            o_job.res.drop_cause = CAUSE_SRC_IP;
        end else begin
            o_job.fin = 1'b0;
        end
        o_q_push = r_vld && go;
        n_vld    = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_q_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lsps_queue.sv =====
`default_nettype none
module lsps_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lsps_pkg::t_job i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output lsps_pkg::t_job      o_data
);
    import lsps_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/lsps_back.sv =====
`default_nettype none
module lsps_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_empty,
    output logic                        o_q_pop,
    input  wire lsps_pkg::t_job         i_job,
    output logic                        o_rd_en,
    output logic [lsps_pkg::SEC_AW-1:0] o_rd_addr,
    input  wire lsps_pkg::t_sec         i_rd,
    output logic                        o_idle,
    output logic                        o_empty,
    input  wire logic                   i_pop,
    output lsps_pkg::t_out              o_result
);
    import lsps_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SWEEP  = 3'd1;
    localparam logic [2:0] S_LEARN  = 3'd2;
    localparam logic [2:0] S_EGRESS = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    t_fwd              r_mem [FWD_ENTRIES];
    t_fwd              r_rd_data;
    logic [2:0]        r_state,   n_state;
    logic [FWD_CW-1:0] r_idx,     n_idx;
    logic [FWD_CW-1:0] r_count,   n_count;
    logic              r_rd_vld,  n_rd_vld;
    logic [FWD_AW-1:0] r_rd_idx,  n_rd_idx;
    logic              r_shit,    n_shit;
    logic [FWD_AW-1:0] r_sidx,    n_sidx;
    logic              r_dhit,    n_dhit;
    logic [4:0]        r_dport,   n_dport;
    logic              r_out_vld, n_out_vld;
    t_job              r_job,     n_job;
    t_out              r_res,     n_res;
    t_out              r_out,     n_out;
    logic              mem_rd;
    logic              mem_wr;
    logic [FWD_AW-1:0] mem_waddr;
    logic              room;
    logic              same;
    logic              dhit;
    logic [4:0]        dport;

    assign room = r_count < FWD_CW'(FWD_ENTRIES);
    assign same = r_job.smac == r_job.dmac;
    assign dhit = same ? (r_shit || room) : r_dhit;
    assign dport = same ? r_job.port : r_dport;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_count   = r_count;
        n_rd_vld  = r_rd_vld;
        n_rd_idx  = r_rd_idx;
        n_shit    = r_shit;
        n_sidx    = r_sidx;
        n_dhit    = r_dhit;
        n_dport   = r_dport;
        n_out_vld = r_out_vld;
        n_job     = r_job;
        n_res     = r_res;
        n_out     = r_out;
        o_q_pop   = 1'b0;
        mem_rd    = 1'b0;
        mem_wr    = 1'b0;
        mem_waddr = r_shit ? r_sidx : r_count[FWD_AW-1:0];
        o_rd_en   = 1'b0;
        o_rd_addr = sec_addr(dport);
        if (i_pop && r_out_vld) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop  = 1'b1;
                    n_job    = i_job;
                    n_res    = i_job.res;
                    n_idx    = '0;
                    n_rd_vld = 1'b0;
                    n_shit   = 1'b0;
                    n_dhit   = 1'b0;
                    n_state  = i_job.fin ? S_DONE : S_SWEEP;
                end
            end
            S_SWEEP: begin
                // walk the filled part of the table, one entry a cycle
                mem_rd   = r_idx < r_count;
                n_rd_vld = mem_rd;
                n_rd_idx = r_idx[FWD_AW-1:0];
                if (mem_rd) begin
                    n_idx = r_idx + FWD_CW'(1);
                end
                if (r_rd_vld && r_rd_data.mac == r_job.smac) begin
                    n_shit = 1'b1;
                    n_sidx = r_rd_idx;
                end
                if (r_rd_vld && r_rd_data.mac == r_job.dmac) begin
                    n_dhit  = 1'b1;
                    n_dport = r_rd_data.port;
                end
                if (!mem_rd && !r_rd_vld) begin
                    n_state = S_LEARN;
                end
            end
            S_LEARN: begin
                mem_wr = r_shit || room;
                if (!r_shit && room) begin
                    n_count = r_count + FWD_CW'(1);
                end
                n_dhit  = dhit;
                n_dport = dport;
                if (!dhit) begin
                    n_res   = '{action: ACT_CONTROLLER, out_port: 5'd0, drop_cause: CAUSE_NONE};
                    n_state = S_DONE;
                end else begin
                    o_rd_en = 1'b1;
                    n_state = S_EGRESS;
                end
            end
            S_EGRESS: begin
                if (port_ok(r_dport) && i_rd.mac_valid && r_job.dmac != i_rd.mac) begin
                    n_res = '{action: ACT_DROP, out_port: 5'd0, drop_cause: CAUSE_DST_MAC};
                end else if (r_dport == r_job.port) begin
                    n_res = '{action: ACT_DROP, out_port: 5'd0, drop_cause: CAUSE_SAME_PORT};
                end else begin
                    n_res = '{action: ACT_REDIRECT, out_port: r_dport, drop_cause: CAUSE_NONE};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_pop) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_shit    <= 1'b0;
            r_dhit    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_shit    <= n_shit;
            r_dhit    <= n_dhit;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_sidx   <= n_sidx;
        r_dport  <= n_dport;
        r_job    <= n_job;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[mem_waddr] <= '{mac: r_job.smac, port: r_job.port};
        end
        if (mem_rd) begin
            r_rd_data <= r_mem[r_idx[FWD_AW-1:0]];
        end
    end

    assign o_idle   = r_state == S_IDLE;
    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

endmodule
`default_nettype wire

// ===== hw/rtl/learning_switch_port_security.sv =====
// channel   handshake           payload
// request   push / full         i_item   (lsps_pkg::t_in)
// result    empty / pop         o_result (lsps_pkg::t_out)
//
// a security write or an early drop passes from the queue straight to the done state, with no table sweep
// a forwarded frame is matched against the learned entries before its source is learned:
// the back end reads the forwarding memory one entry a cycle for both macs
// no clearing pass: the table fills from entry 0, a fill count marks what is valid
// security writes wait in the front end until the back end has drained
// a waiting result does not stop the front end taking the next request
`default_nettype none
module learning_switch_port_security (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire lsps_pkg::t_in  i_item,
    output logic                empty,
    input  wire logic           pop,
    output lsps_pkg::t_out      o_result
);
    import lsps_pkg::*;
    `include "learning_switch_port_security_macros.svh"

    logic              sec_a_en;
    logic [SEC_AW-1:0] sec_a_addr;
    t_sec              sec_a;
    logic              sec_b_en;
    logic [SEC_AW-1:0] sec_b_addr;
    t_sec              sec_b;
    t_sec_wr           sec_wr;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    t_job              q_in;
    t_job              q_out;
    logic              back_idle;
    logic              drain;

    assign drain = q_empty && back_idle;

    lsps_sectab u_sectab (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (sec_wr),
        .i_rd_a_en   (sec_a_en),
        .i_rd_a_addr (sec_a_addr),
        .o_rd_a      (sec_a),
        .i_rd_b_en   (sec_b_en),
        .i_rd_b_addr (sec_b_addr),
        .o_rd_b      (sec_b)
    );

    lsps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_item    (i_item),
        .i_drain   (drain),
        .o_rd_en   (sec_a_en),
        .o_rd_addr (sec_a_addr),
        .i_rd      (sec_a),
        .o_wr      (sec_wr),
        .o_q_push  (q_push),
        .i_q_full  (q_full),
        .o_job     (q_in)
    );

    lsps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    lsps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_job     (q_out),
        .o_rd_en   (sec_b_en),
        .o_rd_addr (sec_b_addr),
        .i_rd      (sec_b),
        .o_idle    (back_idle),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

    `LSPS_ASSERT_NOW(a_wr_drained, i_clk, i_rst_n, sec_wr.en, q_empty && back_idle)
    `LSPS_ASSERT_NOW(a_q_no_overflow, i_clk, i_rst_n, q_push, !q_full)
    `LSPS_ASSERT_NEXT(a_front_holds, i_clk, i_rst_n, push && !full, full)
    `LSPS_ASSERT_NOW(a_b_read_idle, i_clk, i_rst_n, sec_b_en, !q_pop && !sec_wr.en)

endmodule
`default_nettype wire
